// ===== rtl/core/jss_pkg.sv =====
// Shared types and constants for the Jacobi five-point stencil sweep unit.
// No dependencies; imported by jss_ctrl, jss_datapath and the top level.

package jss_pkg;

    localparam int MAX_ROW        = 1026;
    localparam int DATA_BITS      = 32;
    localparam int GAIN_BITS      = 32;
    localparam int LEN_BITS       = 11;
    localparam int CFG_INDEX_BITS = 2;
    localparam int ADDR_BITS      = $clog2(MAX_ROW);
    localparam int LEN_MIN        = 3;
    localparam int LEN_RESET      = 14;

    // Q20.12 gains: magnitude product, then drop 12 fraction bits
    localparam int GAIN_FRAC  = 12;
    localparam int SUM_BITS   = DATA_BITS + 1;
    localparam int PROD_BITS  = DATA_BITS + GAIN_BITS;
    localparam int TERM_BITS  = PROD_BITS - GAIN_FRAC;
    // two terms plus source: signed accumulator and its magnitude
    localparam int ACC_BITS   = TERM_BITS + 3;
    localparam int MAG_BITS   = ACC_BITS - 1;
    localparam int SCALE_BITS = 32;
    localparam int HI_BITS    = MAG_BITS - SCALE_BITS;

    localparam logic [MAG_BITS-1:0] NEG_LIMIT = MAG_BITS'(1) << (DATA_BITS - 1);
    localparam logic [MAG_BITS-1:0] POS_LIMIT = NEG_LIMIT - MAG_BITS'(1);
    localparam logic signed [DATA_BITS-1:0] DATA_MAX = {1'b0, {(DATA_BITS-1){1'b1}}};
    localparam logic signed [DATA_BITS-1:0] DATA_MIN = {1'b1, {(DATA_BITS-1){1'b0}}};

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ROW_LENGTH   = 2'd0,
        CFG_CENTER_SCALE = 2'd1,
        CFG_ROW_GAIN     = 2'd2,
        CFG_COL_GAIN     = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_ABS1,
        ST_MUL1,
        ST_MAG1,
        ST_ACC,
        ST_ABS2,
        ST_MUL2,
        ST_MAG2,
        ST_SAT,
        ST_DIFF,
        ST_ABSD,
        ST_DONE
    } jss_state_t;

    typedef struct packed {
        logic accept;
        logic fetch;
        logic load_out;
    } jss_cmd_t;

    typedef struct packed {
        logic produce;
        logic out_free;
    } jss_status_t;

endpackage

// ===== rtl/core/jss_ctrl.sv =====
// Sequencer for the stencil sweep unit: walks one cell through the datapath.
// Depends on jss_pkg.

module jss_ctrl import jss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  jss_status_t status,
    output jss_cmd_t    cmd
);

    jss_state_t state_reg;
    jss_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.accept   = 1'b0;
        cmd.fetch    = 1'b0;
        cmd.load_out = 1'b0;
        item_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                cmd.accept = item_valid;
                if (item_valid)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                // window and taps move here; cells that finish no centre stop
                cmd.fetch  = 1'b1;
                state_next = status.produce ? ST_ABS1 : ST_IDLE;
            end
            ST_ABS1: state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MAG1;
            ST_MAG1: state_next = ST_ACC;
            ST_ACC:  state_next = ST_ABS2;
            ST_ABS2: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_MAG2;
            ST_MAG2: state_next = ST_SAT;
            ST_SAT:  state_next = ST_DIFF;
            ST_DIFF: state_next = ST_ABSD;
            ST_ABSD: state_next = ST_DONE;
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/jss_datapath.sv =====
// Datapath of the stencil sweep unit: config registers, row buffers,
// stencil window, fixed-point arithmetic chain and result register. Depends on jss_pkg.

module jss_datapath import jss_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  jss_cmd_t                        cmd,
    output jss_status_t                     status,
    input  logic                            cfg_valid,
    input  logic [CFG_INDEX_BITS-1:0]       cfg_index,
    input  logic [DATA_BITS-1:0]            cfg_data,
    input  logic signed [DATA_BITS-1:0]     old_value,
    input  logic signed [DATA_BITS-1:0]     source_value,
    input  logic                            last_sample,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic signed [DATA_BITS-1:0]     new_value,
    output logic [DATA_BITS-1:0]            change,
    output logic [DATA_BITS-1:0]            max_change,
    output logic                            sweep_done
);

    // configuration
    logic [LEN_BITS-1:0]   row_length_reg;
    logic [SCALE_BITS-1:0] center_scale_reg;
    logic [GAIN_BITS-1:0]  row_gain_reg;
    logic [GAIN_BITS-1:0]  col_gain_reg;

    // raster position and sweep state
    logic [ADDR_BITS-1:0]  col_reg;
    logic [1:0]            row_reg;
    logic [DATA_BITS-1:0]  run_max_reg;
    logic                  produce_reg;
    logic                  last_reg;
    logic                  slot_reg;

    // row buffers
    logic signed [DATA_BITS-1:0] row_a_mem [MAX_ROW];
    logic signed [DATA_BITS-1:0] row_b_mem [MAX_ROW];
    logic signed [DATA_BITS-1:0] src_mem   [MAX_ROW];
    logic signed [DATA_BITS-1:0] rd_a_reg;
    logic signed [DATA_BITS-1:0] rd_b_reg;
    logic signed [DATA_BITS-1:0] rd_src_reg;

    // window: cell to the left in this row, saved upper value, saved source
    logic signed [DATA_BITS-1:0] win_down_reg;
    logic signed [DATA_BITS-1:0] win_up_reg;
    logic signed [DATA_BITS-1:0] win_src_reg;
    // previous row at columns c-1 and c-2
    logic signed [DATA_BITS-1:0] tap1_reg;
    logic signed [DATA_BITS-1:0] tap2_reg;

    // operands held for the arithmetic chain
    logic signed [DATA_BITS-1:0] up_reg;
    logic signed [DATA_BITS-1:0] down_reg;
    logic signed [DATA_BITS-1:0] left_reg;
    logic signed [DATA_BITS-1:0] old_reg;
    logic signed [DATA_BITS-1:0] src_reg;

    // arithmetic chain
    logic signed [SUM_BITS-1:0]  sum_ud_reg;
    logic signed [SUM_BITS-1:0]  sum_lr_reg;
    logic [SUM_BITS-1:0]         mag_ud_reg;
    logic [SUM_BITS-1:0]         mag_lr_reg;
    logic                        neg_ud1_reg;
    logic                        neg_lr1_reg;
    logic [PROD_BITS-1:0]        prod_ud_reg;
    logic [PROD_BITS-1:0]        prod_lr_reg;
    logic                        hi_ud_reg;
    logic                        hi_lr_reg;
    logic                        neg_ud2_reg;
    logic                        neg_lr2_reg;
    logic [TERM_BITS-1:0]        term_ud_reg;
    logic [TERM_BITS-1:0]        term_lr_reg;
    logic                        neg_ud3_reg;
    logic                        neg_lr3_reg;
    logic signed [ACC_BITS-1:0]  acc_reg;
    logic [MAG_BITS-1:0]         acc_mag_reg;
    logic                        acc_neg1_reg;
    logic [MAG_BITS-1:0]         phi_reg;
    logic [PROD_BITS-1:0]        plo_reg;
    logic                        acc_neg2_reg;
    logic [MAG_BITS-1:0]         q_reg;
    logic                        acc_neg3_reg;
    logic signed [DATA_BITS-1:0] nv_reg;
    logic signed [DATA_BITS:0]   diff_reg;
    logic [DATA_BITS-1:0]        chg_reg;

    // result register
    logic                        result_valid_reg;
    logic signed [DATA_BITS-1:0] new_value_reg;
    logic [DATA_BITS-1:0]        change_reg;
    logic [DATA_BITS-1:0]        max_change_reg;
    logic                        sweep_done_reg;

    logic [LEN_BITS-1:0]         len_eff;
    logic [ADDR_BITS-1:0]        col_last;
    logic                        row_end;
    logic                        slot;
    logic                        produce_now;
    logic signed [DATA_BITS-1:0] right_val;
    logic signed [DATA_BITS-1:0] up_val;
    logic [PROD_BITS-1:0]        full_ud;
    logic [PROD_BITS-1:0]        full_lr;
    logic signed [ACC_BITS-1:0]  t_ud;
    logic signed [ACC_BITS-1:0]  t_lr;
    logic signed [DATA_BITS-1:0] nv_val;
    logic [DATA_BITS-1:0]        max_new;

    always_comb
    begin
        if (row_length_reg < LEN_BITS'(LEN_MIN))
        begin
            len_eff = LEN_BITS'(LEN_MIN);
        end
        else if (row_length_reg > LEN_BITS'(MAX_ROW))
        begin
            len_eff = LEN_BITS'(MAX_ROW);
        end
        else
        begin
            len_eff = row_length_reg;
        end
    end

    assign col_last    = ADDR_BITS'(len_eff - LEN_BITS'(1));
    assign row_end     = (col_reg >= col_last);
    assign slot        = row_reg[0];
    assign produce_now = row_reg[1] && (col_reg >= ADDR_BITS'(2));

    // slot 0 lives in row_a; the other buffer holds the previous row
    assign right_val = slot_reg ? rd_a_reg : rd_b_reg;
    assign up_val    = slot_reg ? rd_b_reg : rd_a_reg;

    assign status.produce  = produce_reg;
    assign status.out_free = !result_valid_reg || !result_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg   <= LEN_BITS'(LEN_RESET);
            center_scale_reg <= '0;
            row_gain_reg     <= '0;
            col_gain_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ROW_LENGTH:   row_length_reg   <= cfg_data[LEN_BITS-1:0];
                CFG_CENTER_SCALE: center_scale_reg <= cfg_data;
                CFG_ROW_GAIN:     row_gain_reg     <= cfg_data;
                CFG_COL_GAIN:     col_gain_reg     <= cfg_data;
            endcase
        end
    end

    // buffers: read old contents and write the new cell at the same column
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_a_reg   <= row_a_mem[col_reg];
            rd_b_reg   <= row_b_mem[col_reg];
            rd_src_reg <= src_mem[col_reg];
            src_mem[col_reg] <= source_value;
            if (slot)
            begin
                row_b_mem[col_reg] <= old_value;
            end
            else
            begin
                row_a_mem[col_reg] <= old_value;
            end
        end
    end

    // position, window and sweep state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg          <= '0;
            row_reg          <= '0;
            run_max_reg      <= '0;
            produce_reg      <= 1'b0;
            last_reg         <= 1'b0;
            slot_reg         <= 1'b0;
            win_down_reg     <= '0;
            win_up_reg       <= '0;
            win_src_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                produce_reg  <= produce_now;
                last_reg     <= last_sample;
                slot_reg     <= slot;
                win_down_reg <= old_value;
                if (last_sample)
                begin
                    col_reg <= '0;
                    row_reg <= '0;
                    if (!produce_now)
                    begin
                        run_max_reg <= '0;
                    end
                end
                else if (row_end)
                begin
                    col_reg <= '0;
                    // saturate at 3 <-> 2 so buffer parity keeps alternating
                    row_reg <= (row_reg == 2'd3) ? 2'd2 : row_reg + 2'd1;
                end
                else
                begin
                    col_reg <= col_reg + ADDR_BITS'(1);
                end
            end
            if (cmd.fetch)
            begin
                win_up_reg  <= up_val;
                win_src_reg <= rd_src_reg;
            end
            if (cmd.load_out)
            begin
                result_valid_reg <= 1'b1;
                run_max_reg      <= last_reg ? '0 : max_new;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // operand capture and previous-row taps
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            up_reg   <= win_up_reg;
            down_reg <= win_down_reg;
            src_reg  <= win_src_reg;
            left_reg <= tap2_reg;
            old_reg  <= tap1_reg;
        end
        if (cmd.fetch)
        begin
            tap2_reg <= tap1_reg;
            tap1_reg <= right_val;
        end
    end

    assign full_ud = prod_ud_reg + (hi_ud_reg ? {row_gain_reg, {DATA_BITS{1'b0}}} : '0);
    assign full_lr = prod_lr_reg + (hi_lr_reg ? {col_gain_reg, {DATA_BITS{1'b0}}} : '0);
    assign t_ud = neg_ud3_reg ? -ACC_BITS'(term_ud_reg) : ACC_BITS'(term_ud_reg);
    assign t_lr = neg_lr3_reg ? -ACC_BITS'(term_lr_reg) : ACC_BITS'(term_lr_reg);

    always_comb
    begin
        if (acc_neg3_reg)
        begin
            nv_val = (q_reg > NEG_LIMIT) ? DATA_MIN : DATA_BITS'(0) - q_reg[DATA_BITS-1:0];
        end
        else
        begin
            nv_val = (q_reg > POS_LIMIT) ? DATA_MAX : q_reg[DATA_BITS-1:0];
        end
    end

    assign max_new = (chg_reg > run_max_reg) ? chg_reg : run_max_reg;

    // arithmetic chain; operands hold still while one cell walks through
    always_ff @(posedge clk)
    begin
        sum_ud_reg  <= SUM_BITS'(up_reg) + SUM_BITS'(down_reg);
        sum_lr_reg  <= SUM_BITS'(left_reg) + SUM_BITS'(right_val);

        neg_ud1_reg <= sum_ud_reg[SUM_BITS-1];
        neg_lr1_reg <= sum_lr_reg[SUM_BITS-1];
        mag_ud_reg  <= sum_ud_reg[SUM_BITS-1] ? -sum_ud_reg : sum_ud_reg;
        mag_lr_reg  <= sum_lr_reg[SUM_BITS-1] ? -sum_lr_reg : sum_lr_reg;

        // magnitude can reach 2^32: top bit added back as a shifted gain
        prod_ud_reg <= mag_ud_reg[DATA_BITS-1:0] * row_gain_reg;
        prod_lr_reg <= mag_lr_reg[DATA_BITS-1:0] * col_gain_reg;
        hi_ud_reg   <= mag_ud_reg[DATA_BITS];
        hi_lr_reg   <= mag_lr_reg[DATA_BITS];
        neg_ud2_reg <= neg_ud1_reg;
        neg_lr2_reg <= neg_lr1_reg;

        term_ud_reg <= full_ud[PROD_BITS-1:GAIN_FRAC];
        term_lr_reg <= full_lr[PROD_BITS-1:GAIN_FRAC];
        neg_ud3_reg <= neg_ud2_reg;
        neg_lr3_reg <= neg_lr2_reg;

        acc_reg      <= t_ud + t_lr - ACC_BITS'(src_reg);

        acc_neg1_reg <= acc_reg[ACC_BITS-1];
        acc_mag_reg  <= MAG_BITS'(acc_reg[ACC_BITS-1] ? -acc_reg : acc_reg);

        // Q0.32 scale, split into high and low partial products
        phi_reg      <= acc_mag_reg[MAG_BITS-1:SCALE_BITS] * center_scale_reg;
        plo_reg      <= acc_mag_reg[SCALE_BITS-1:0] * center_scale_reg;
        acc_neg2_reg <= acc_neg1_reg;

        q_reg        <= phi_reg + MAG_BITS'(plo_reg[PROD_BITS-1:SCALE_BITS]);
        acc_neg3_reg <= acc_neg2_reg;

        nv_reg   <= nv_val;
        diff_reg <= (DATA_BITS+1)'(nv_reg) - (DATA_BITS+1)'(old_reg);
        chg_reg  <= diff_reg[DATA_BITS] ? DATA_BITS'(-diff_reg) : DATA_BITS'(diff_reg);
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            new_value_reg  <= nv_reg;
            change_reg     <= chg_reg;
            max_change_reg <= max_new;
            sweep_done_reg <= last_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign new_value    = new_value_reg;
    assign change       = change_reg;
    assign max_change   = max_change_reg;
    assign sweep_done   = sweep_done_reg;

endmodule

// ===== rtl/core/jacobi_stencil_sweep_unit.sv =====
// Jacobi five-point stencil sweep unit, top level; uses jss_pkg, jss_ctrl, jss_datapath.
// A cell that finishes an interior centre is accepted, fetched from the buffers,
// then walks a ten-step arithmetic chain with two multiplier stages; its result is
// loaded once the output register is free. Other cells end at the fetch. One cell is
// in work at a time; the next is taken while a result waits in the output register.
// Reset clears position, window, running maximum and sets row_length to 14.

module jacobi_stencil_sweep_unit import jss_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic signed [DATA_BITS-1:0] old_value,
    input  logic signed [DATA_BITS-1:0] source_value,
    input  logic                        last_sample,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic signed [DATA_BITS-1:0] new_value,
    output logic [DATA_BITS-1:0]        change,
    output logic [DATA_BITS-1:0]        max_change,
    output logic                        sweep_done,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [DATA_BITS-1:0]        cfg_data
);

    jss_cmd_t    cmd;
    jss_status_t status;

    // registers take a write beat in any cycle
    assign cfg_ready = 1'b1;

    jss_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    jss_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .old_value    (old_value),
        .source_value (source_value),
        .last_sample  (last_sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .new_value    (new_value),
        .change       (change),
        .max_change   (max_change),
        .sweep_done   (sweep_done)
    );

endmodule
